### rtl/stsrch_pkg.sv
// shared types and constants for the sorted table search block
`default_nettype none

package stsrch_pkg;

    // width of a result position and of the search bounds
    localparam int PosW = 10;
    localparam int DataW = 32;

    typedef logic signed [PosW-1:0] pos_t;
    typedef logic signed [DataW-1:0] data_t;

    // request operation codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EXACT = 2'd1,
        OP_LOWER = 2'd2,
        OP_UPPER = 2'd3
    } op_t;

    // answer for not found or empty table
    localparam pos_t POS_NONE = -10'sd1;

    // outcome of one probe compare
    typedef struct packed {
        logic hit;
        pos_t lo;
        pos_t hi;
    } probe_res_t;

endpackage

`default_nettype wire

### rtl/stsrch_ram.sv
// generic single write port ram with registered read
`default_nettype none

module stsrch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/stsrch_probe.sv
// compare unit: one probe of the table and the bound update it implies
`default_nettype none

module stsrch_probe
    import stsrch_pkg::*;
(
    input  wire op_t        mode,
    input  wire pos_t       lo,
    input  wire pos_t       hi,
    input  wire pos_t       mid,
    input  wire data_t      entry,
    input  wire data_t      target,
    output probe_res_t      res
);

    logic eq;
    logic lt;

    // signed compare of the probed entry against the target
    assign eq = (entry == target);
    assign lt = (entry < target);

    // narrow the bounds by mode
    always_comb
    begin
        res.hit = 1'b0;
        res.lo  = lo;
        res.hi  = hi;
        unique case (mode)
            OP_EXACT:
            begin
                if (eq)
                begin
                    res.hit = 1'b1;
                end
                else if (lt)
                begin
                    res.lo = mid + pos_t'(1);
                end
                else
                begin
                    res.hi = mid - pos_t'(1);
                end
            end
            OP_LOWER:
            begin
                if (!lt)
                begin
                    res.hi = mid;
                end
                else
                begin
                    res.lo = mid + pos_t'(1);
                end
            end
            OP_UPPER:
            begin
                if (lt || eq)
                begin
                    res.lo = mid + pos_t'(1);
                end
                else
                begin
                    res.hi = mid;
                end
            end
            default:
            begin
                res.hit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sorted_table_search.sv
// top level: table store, probe sequencer and result register
// a load request writes the table directly and gives no result
// a query runs p probes, each an address step (S_CHECK) then a compare step (S_CMP),
//   plus a final bound check and a hand-over to the result register (S_DONE),
//   with p <= floor(log2(n))+1; the single table read port sets the pace
// reset clears the sequencer, the table size (to 0) and the result valid flag;
//   table contents are not cleared and must be loaded before use
`default_nettype none

module sorted_table_search
    import stsrch_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // table size register write
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [8:0]        cfg_data,
    // requests
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        op,
    input  wire logic [7:0]        index,
    input  wire logic signed [31:0] value,
    // results
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [9:0]      position
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [8:0] size_reg;
    op_t        mode_reg, mode_next;
    data_t      target_reg, target_next;
    pos_t       lo_reg, lo_next;
    pos_t       hi_reg, hi_next;
    pos_t       mid_reg, mid_next;
    pos_t       result_reg, result_next;
    logic       out_valid_reg, out_valid_next;
    pos_t       position_reg, position_next;

    op_t        op_in;
    pos_t       used_n;
    pos_t       diff;
    pos_t       mid_calc;
    logic       keep_going;
    logic       wr_ok;
    logic       ram_we;
    data_t      ram_rdata;
    probe_res_t probe;

    assign op_in = op_t'(op);

    // entries in use, saturated at the table depth
    assign used_n = ({23'd0, size_reg} > 32'(DEPTH)) ? pos_t'(DEPTH) : pos_t'({1'b0, size_reg});

    // loads beyond the table are dropped
    assign wr_ok = ({24'd0, index} < 32'(DEPTH));

    // next probe point and loop condition
    assign diff       = hi_reg - lo_reg;
    assign mid_calc   = lo_reg + (diff >>> 1);
    assign keep_going = (mode_reg == OP_EXACT) ? (lo_reg <= hi_reg) : (lo_reg < hi_reg);

    // table store
    stsrch_ram #(
        .WIDTH(DataW),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(index)),
        .wdata(value),
        .raddr(AW'($unsigned(mid_calc))),
        .rdata(ram_rdata)
    );

    // compare unit shared by every probe
    stsrch_probe u_probe (
        .mode  (mode_reg),
        .lo    (lo_reg),
        .hi    (hi_reg),
        .mid   (mid_reg),
        .entry (ram_rdata),
        .target(target_reg),
        .res   (probe)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        target_next    = target_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        position_next  = position_reg;
        ram_we         = 1'b0;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op_in == OP_LOAD)
                    begin
                        ram_we = wr_ok;
                    end
                    else
                    begin
                        mode_next   = op_in;
                        target_next = value;
                        lo_next     = '0;
                        hi_next     = (op_in == OP_EXACT) ? (used_n - pos_t'(1)) : used_n;
                        if (used_n == '0)
                        begin
                            result_next = POS_NONE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (keep_going)
                begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else
                begin
                    unique case (mode_reg)
                        OP_EXACT: result_next = POS_NONE;
                        OP_LOWER: result_next = lo_reg;
                        default:  result_next = hi_reg - pos_t'(1);
                    endcase
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                if (probe.hit)
                begin
                    result_next = mid_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    lo_next    = probe.lo;
                    hi_next    = probe.hi;
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    position_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    // search payload
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        target_reg   <= target_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        result_reg   <= result_next;
        position_reg <= position_next;
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign position  = position_reg;

endmodule

`default_nettype wire

### rtl/stsrch_chk.sv
// port level checker for the sorted table search block, with its bind
`default_nettype none

module stsrch_chk
    import stsrch_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [1:0]        op,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic signed [9:0] position
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position))
        else $error("result changed or dropped while stalled");

    // a query request keeps the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op != OP_LOAD) |=> !in_ready)
        else $error("ready right after a query request");

    // a load request leaves the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_LOAD) |=> in_ready)
        else $error("load request made the block busy");

    // positions are never below minus one
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!position[9] || (position == POS_NONE)))
        else $error("negative position other than not found");

endmodule

bind sorted_table_search stsrch_chk u_stsrch_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .position (position)
);

`default_nettype wire
